/* src/spq_pkg.sv */
// ============================================================================
// spq_pkg: shared types and codes of the sorted priority queue
// Holds the operation codes, the status codes and the command word that the
// top level broadcasts to every cell of the chain.
// ============================================================================
package spq_pkg;

    // Width of one stored value.
    localparam int unsigned VALUE_W = 32;

    // Operation codes of the kind field.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Command broadcast to all cells in the cycle a word is taken.
    typedef struct packed {
        logic                       ins_en;  // insert is carried out
        logic                       del_en;  // delete is carried out
        logic signed [VALUE_W-1:0]  value;   // operand of the word
    } t_cmd;

    // Compare flags that one cell reports to the top level and its neighbor.
    typedef struct packed {
        logic lt;   // occupied and operand is below the stored value
        logic eq;   // occupied and operand equals the stored value
        logic ge;   // occupied and stored value is at or above the operand
    } t_flags;

endpackage

/* src/sorted_priority_queue_core.sv */
// ============================================================================
// sorted_priority_queue_core: sorted priority queue of signed values
// Chain of DEPTH cells holding values in ascending order, with a result
// register on the output side.
// ============================================================================
// Each input word is completed in the cycle it is taken: every cell compares
// its value with the operand in parallel and shifts left or right in the
// same edge, so one word is accepted per clock and its result word appears
// on the next edge. The result register frees as soon as it is taken, so
// the input is stalled only while a result is held against a stall from the
// output side. Inserts keep equal values in arrival order, deletes remove the
// lowest equal entry. Every word returns status, count and the head entry.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    // Output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [3:0]                 o_count,
    output logic                       o_head_valid,
    output logic signed [VALUE_W-1:0]  o_head_value
);

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;
    logic                         r_out_valid;
    logic                         n_out_valid;
    t_status                      n_status;
    logic [FILL_W+3:0]            fill_ext;
    logic                         in_acc;
    logic                         hit;
    logic                         full;
    logic                         empty;
    t_cmd                         cmd;

    t_flags                       flags  [DEPTH];
    logic signed [VALUE_W-1:0]    values [DEPTH];
    logic signed [VALUE_W-1:0]    nexts  [DEPTH];
    logic [DEPTH-1:0]             eq_vec;

    // Handshake: a word is taken unless a held result is stalled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full  = (r_fill == FILL_W'(DEPTH));
    assign empty = (r_fill == '0);
    assign hit   = |eq_vec;

    // Decide the status and the command broadcast to the cells.
    always_comb begin
        cmd.value  = i_value;
        cmd.ins_en = 1'b0;
        cmd.del_en = 1'b0;
        n_fill     = r_fill;
        n_status   = ST_DONE;
        if (i_kind == KIND_INSERT) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                cmd.ins_en = in_acc;
                n_fill     = r_fill + 1'b1;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else if (!hit) begin
                n_status = ST_NOTFOUND;
            end else begin
                cmd.del_en = in_acc;
                n_fill     = r_fill - 1'b1;
            end
        end
    end

    // Chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                      left_lt;
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_lt    = 1'b0;
            assign left_value = values[g];
        end else begin : g_mid
            assign left_lt    = flags[g-1].lt;
            assign left_value = values[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_value = values[g];
        end else begin : g_inner
            assign right_value = values[g+1];
        end

        assign eq_vec[g] = flags[g].eq;

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occ         (FILL_W'(g) < r_fill),
            .i_at_end      (FILL_W'(g) == r_fill),
            .i_left_lt     (left_lt),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_flags       (flags[g]),
            .o_value       (values[g]),
            .o_next        (nexts[g])
        );
    end

    assign n_out_valid = in_acc || (r_out_valid && i_out_stall);
    assign fill_ext    = {4'b0000, n_fill};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_fill <= n_fill;
            end
        end
    end

    // Result register, loaded with the state after the word.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            o_status     <= n_status;
            o_count      <= fill_ext[3:0];
            o_head_valid <= (n_fill != '0);
            o_head_value <= (n_fill != '0) ? nexts[0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    // The fill never passes the number of cells.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("fill exceeds depth");

    // An insert taken while full is reported as full and leaves the fill.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_INSERT && full)
            |=> (o_status == ST_FULL && $stable(r_fill)))
        else $error("insert into full queue not rejected");

    // A delete taken while empty is reported as empty.
    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_DELETE && empty) |=> (o_status == ST_EMPTY))
        else $error("delete from empty queue not rejected");

    // A word taken always yields a result word on the next edge.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_out_valid && o_head_valid == (r_fill != '0)))
        else $error("result word missing or head flag wrong");

endmodule

/* src/spq_cell.sv */
// ============================================================================
// spq_cell: one position of the sorted queue
// Holds one value, compares it against the broadcast operand and takes its
// next value from itself, its left neighbor, its right neighbor or the
// operand, so that a whole insert or delete completes within its own cycle.
// ============================================================================
module spq_cell
    import spq_pkg::*;
(
    input  logic                       i_clk,
    input  t_cmd                       i_cmd,
    input  logic                       i_occ,          // position holds an entry
    input  logic                       i_at_end,       // first free position
    input  logic                       i_left_lt,      // left cell shifts right
    input  logic signed [VALUE_W-1:0]  i_left_value,
    input  logic signed [VALUE_W-1:0]  i_right_value,
    output t_flags                     o_flags,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic signed [VALUE_W-1:0]  o_next
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // Signed compares of the operand against the held value.
    always_comb begin
        o_flags.lt = i_occ && (i_cmd.value < r_value);
        o_flags.eq = i_occ && (i_cmd.value == r_value);
        o_flags.ge = i_occ && (r_value >= i_cmd.value);
    end

    // Next value: an insert shifts the tail right and drops the operand into
    // the first larger position, or else the first free one; a delete pulls
    // everything from the first match onward one place to the left.
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins_en) begin
            if (i_left_lt) begin
                n_value = i_left_value;
            end else if (o_flags.lt || i_at_end) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.del_en) begin
            if (o_flags.ge) begin
                n_value = i_right_value;
            end
        end
    end

    // Entry storage; it is only read where it was written before.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_next  = n_value;

endmodule

/* tb/sv/spq_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// spq_checker: result checker of the sorted priority queue
// Watches both channels of the queue core, keeps its own sorted copy of the
// stored values, predicts one result word per accepted input word and
// compares every accepted result word field by field in arrival order.
// ============================================================================
module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel as seen by the core
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    // Output channel as seen by the core
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_status,
    input  logic [3:0]                 i_count,
    input  logic                       i_head_valid,
    input  logic signed [VALUE_W-1:0]  i_head_value,
    // Totals handed to the testbench top
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_full_seen,
    output int                         o_empty_seen,
    output int                         o_miss_seen
);

    // One predicted result word.
    typedef struct {
        t_status                   status;
        logic [3:0]                count;
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
    } t_queue_outcome;

    // Shadow copy of the sorted store.
    logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
    int                        sorted_fill;

    // Predicted result words waiting for the core.
    t_queue_outcome outcome_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
        o_miss_seen  = 0;
        sorted_fill  = 0;
    end

    // Print one line per mismatch and count it.
    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // Apply one input word to the shadow store and return its result word.
    task automatic apply_word(input logic kind, input logic signed [VALUE_W-1:0] value,
                              output t_queue_outcome res);
        int  pos;
        int  j;
        logic found;
        found = 1'b0;
        pos   = sorted_fill;
        if (kind == KIND_INSERT) begin
            if (sorted_fill >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // Equal values stay ahead of the new one.
                for (j = 0; j < sorted_fill; j++) begin
                    if (!found && value < sorted_vals[j]) begin
                        pos   = j;
                        found = 1'b1;
                    end
                end
                for (j = sorted_fill; j > pos; j--) begin
                    sorted_vals[j] = sorted_vals[j-1];
                end
                sorted_vals[pos] = value;
                sorted_fill++;
                res.status = ST_DONE;
            end
        end else begin
            if (sorted_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // The lowest matching position is removed.
                for (j = 0; j < sorted_fill; j++) begin
                    if (!found && sorted_vals[j] == value) begin
                        pos   = j;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (j = pos; j + 1 < sorted_fill; j++) begin
                        sorted_vals[j] = sorted_vals[j+1];
                    end
                    sorted_fill--;
                    res.status = ST_DONE;
                end
            end
        end
        res.count      = sorted_fill[3:0];
        res.head_valid = (sorted_fill > 0);
        res.head_value = (sorted_fill > 0) ? sorted_vals[0] : '0;
    endtask

    // Sample both channels at each edge; result words are older than the
    // input word taken at the same edge, so they are checked first.
    always @(posedge i_clk) begin
        t_queue_outcome want;
        t_queue_outcome next_res;
        if (!i_rst_n) begin
            sorted_fill = 0;
            outcome_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    report_error("result word arrived with nothing expected");
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status != want.status)
                        report_error($sformatf("word %0d status got %0d expected %0d",
                                               o_checked, i_status, want.status));
                    if (i_count != want.count)
                        report_error($sformatf("word %0d count got %0d expected %0d",
                                               o_checked, i_count, want.count));
                    if (i_head_valid != want.head_valid)
                        report_error($sformatf("word %0d head_valid got %0b expected %0b",
                                               o_checked, i_head_valid, want.head_valid));
                    if (i_head_value != want.head_value)
                        report_error($sformatf("word %0d head_value got %0d expected %0d",
                                               o_checked, i_head_value, want.head_value));
                    case (want.status)
                        ST_FULL:     o_full_seen++;
                        ST_EMPTY:    o_empty_seen++;
                        ST_NOTFOUND: o_miss_seen++;
                        default:     ;
                    endcase
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_word(i_kind, i_value, next_res);
                outcome_q.push_back(next_res);
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

/* tb/sv/tb_sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_sorted_priority_queue_core: testbench of the sorted priority queue core
// Drives a directed walk through empty, duplicate, full and not-found cases,
// then phases of random inserts and deletes with random gaps and stalls on
// both channels; the checker beside the core predicts and compares results.
// ============================================================================
module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int unsigned DEPTH      = 8;
    localparam int          PHASES     = 30;
    localparam int          PHASE_LEN  = 50;
    localparam int          POOL_SIZE  = 6;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      i_kind       = KIND_INSERT;
    logic signed [VALUE_W-1:0] i_value      = '0;
    logic                      i_out_stall  = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    logic [3:0]                o_count;
    logic                      o_head_valid;
    logic signed [VALUE_W-1:0] o_head_value;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int miss_seen;

    // When set, neither side idles.
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   words_sent = 0;
    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

    always #2 i_clk = ~i_clk;

    sorted_priority_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_head_valid (o_head_valid),
        .o_head_value (o_head_value)
    );

    spq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_count      (o_count),
        .i_head_valid (o_head_valid),
        .i_head_value (o_head_value),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen),
        .o_miss_seen  (miss_seen)
    );

    // Number of idle cycles for the next word on either side.
    function automatic int draw_idle();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // Hold each result word off for a random number of cycles once the
    // previous one was taken.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            stall_left = draw_idle();
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        i_out_stall <= (stall_left > 0);
    end

    // Offer one word after a random gap and wait until it is taken. Valid
    // stays high across back-to-back words.
    task automatic send_word(input logic kind, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // Refill the operand pool: extremes, small values near zero and fully
    // random ones, so that deletes often find a match.
    task automatic refill_pool();
        int j;
        for (j = 0; j < POOL_SIZE; j++) begin
            case ($urandom_range(0, 3))
                0:       value_pool[j] = ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
                1:       value_pool[j] = $signed($urandom_range(0, 8)) - 4;
                default: value_pool[j] = $urandom;
            endcase
        end
    endtask

    // Stimulus.
    initial begin
        int ph;
        int n;
        int ins_pct;
        int guard;
        logic kind;
        logic signed [VALUE_W-1:0] value;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk: empty delete, extremes, duplicates, miss, full.
        send_word(KIND_DELETE, 0);
        send_word(KIND_INSERT, VAL_MAX);
        send_word(KIND_INSERT, VAL_MIN);
        send_word(KIND_INSERT, 0);
        send_word(KIND_INSERT, 0);
        send_word(KIND_INSERT, -1);
        send_word(KIND_DELETE, 5);
        send_word(KIND_DELETE, 0);
        send_word(KIND_INSERT, VAL_MAX);
        send_word(KIND_INSERT, 1);
        send_word(KIND_INSERT, -1);
        send_word(KIND_INSERT, 7);
        send_word(KIND_INSERT, VAL_MIN);
        send_word(KIND_DELETE, VAL_MAX);
        send_word(KIND_INSERT, VAL_MIN);
        send_word(KIND_DELETE, VAL_MIN);
        send_word(KIND_DELETE, VAL_MIN);
        send_word(KIND_DELETE, -1);
        send_word(KIND_DELETE, -1);
        send_word(KIND_DELETE, 0);
        send_word(KIND_DELETE, 1);
        send_word(KIND_DELETE, 7);
        send_word(KIND_DELETE, VAL_MAX);
        send_word(KIND_DELETE, VAL_MIN);

        // Random phases, each leaning toward filling, draining or churning.
        for (ph = 0; ph < PHASES; ph++) begin
            refill_pool();
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       ins_pct = 80;
                1:       ins_pct = 25;
                default: ins_pct = 50;
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                kind  = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
                value = ($urandom_range(0, 9) < 8) ? value_pool[$urandom_range(0, POOL_SIZE-1)]
                                                   : $urandom;
                send_word(kind, value);
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // Drain the outstanding result words, then allow the core's latency.
        guard = 0;
        while (pending != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);

        if (pending != 0)
            $display("%0d expected result words never arrived", pending);
        $display("Sent %0d words and checked %0d results with random gaps and stalls.",
                 words_sent, checked);
        $display("Rejects seen: %0d full inserts, %0d empty deletes, %0d delete misses.",
                 full_seen, empty_seen, miss_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
tb/sv/spq_checker.sv
tb/sv/tb_sorted_priority_queue_core.sv
